FILE: hdl/jpeg_marker_segment_parser_core_assert.svh
// Assertion macros used by the checker file of the marker segment parser.
`ifndef JPEG_MARKER_SEGMENT_PARSER_CORE_ASSERT_SVH
`define JPEG_MARKER_SEGMENT_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define JMSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jmsp assertion failed");

// Next-cycle implication, disabled while reset is applied.
`define JMSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jmsp assertion failed");

`endif

FILE: hdl/jmsp_pkg.sv
`default_nettype none

package jmsp_pkg;

	// Byte values with a fixed meaning in the stream
	localparam logic [7:0] BYTE_FF  = 8'hFF;
	localparam logic [7:0] CODE_SOI = 8'hD8;
	localparam logic [7:0] CODE_EOI = 8'hD9;
	localparam logic [7:0] CODE_SOS = 8'hDA;

	// Byte classes
	localparam logic [2:0] CLS_FILL    = 3'd0;
	localparam logic [2:0] CLS_MARKER  = 3'd1;
	localparam logic [2:0] CLS_LENGTH  = 3'd2;
	localparam logic [2:0] CLS_PAYLOAD = 3'd3;
	localparam logic [2:0] CLS_IMAGE   = 3'd4;
	localparam logic [2:0] CLS_PADDING = 3'd5;
	localparam logic [2:0] CLS_IGNORED = 3'd6;

	// Error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_FILL      = 3'd1;
	localparam logic [2:0] ERR_BAD_CODE  = 3'd2;
	localparam logic [2:0] ERR_SHORT_LEN = 3'd3;
	localparam logic [2:0] ERR_TRUNC     = 3'd4;

	// Configuration register indexes and reset values
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MARKER_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MARKER_HIGH = 1'b1;
	localparam logic [7:0] MARKER_LOW_RST  = 8'd192;
	localparam logic [7:0] MARKER_HIGH_RST = 8'd254;

	// One classified byte as it waits in the result queue
	typedef struct packed {
		logic [7:0] value;
		logic [2:0] cls;
		logic [7:0] marker;
		logic [2:0] err;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

FILE: hdl/jpeg_marker_segment_parser_core.sv
`default_nettype none

// Channel  | Handshake          | Payload
// ---------+--------------------+-----------------------------------------------------
// input    | in_valid/in_stall  | data_byte, last_byte
// output   | out_valid/out_stall| byte_value, byte_class, marker_code, error_code,
//          |                    | last_of_run
// config   | cfg_write          | cfg_index, cfg_data
//
// One byte is accepted per cycle while in_stall is low; the input register holds it
// while it is parsed, and its results go into the result queue that drives the output.
// A byte gives zero, one or two results; a four-entry result queue takes them,
// and a byte that gives two results presents them on the output in turn.
// in_stall rises while the parse register holds a byte and the queue holds three
// or more results. Reset clears control state and loads the marker range 0xC0..0xFE.

module jpeg_marker_segment_parser_core
	import jmsp_pkg::*;
#(
	parameter int unsigned MAX_FILL = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data,
	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 last_byte,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      logic [7:0]           byte_value,
	output      logic [2:0]           byte_class,
	output      logic [7:0]           marker_code,
	output      logic [2:0]           error_code,
	output      logic                 last_of_run
);

	typedef enum logic [2:0] {
		PH_EXPECT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_PAYLOAD,
		PH_ENTROPY,
		PH_PADDING
	} phase_t;

	localparam logic [3:0] FILL_LIMIT = 4'(MAX_FILL);

	// configuration
	logic [7:0] marker_low_q, marker_high_q;

	// input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// parser state
	phase_t      phase_q, phase_n;
	logic [3:0]  fill_q, fill_n;
	logic [15:0] left_q, left_n;
	logic [7:0]  cur_q, cur_n;
	logic        held_q, held_n;
	logic        image_q, image_n;
	logic [2:0]  err_q, err_n;

	// result queue
	result_t    queue_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;

	result_t     r0, r1;
	logic [1:0]  n_res, push;
	logic        advance, accept, pop, trunc, eoi_hit;
	logic [15:0] len;

	// advance when the queue has room for two results
	assign advance  = valid_s1 && (count_q <= 3'd2);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;
	assign push     = advance ? n_res : 2'd0;

	// parse the held byte
	always_comb begin
		phase_n = phase_q;
		fill_n  = fill_q;
		left_n  = left_q;
		cur_n   = cur_q;
		held_n  = held_q;
		image_n = image_q;
		err_n   = err_q;
		r0      = '0;
		r1      = '0;
		n_res   = 2'd0;
		eoi_hit = 1'b0;
		len     = left_q | {8'h00, data_s1};
		trunc   = 1'b0;

		if (err_q != ERR_NONE) begin
			r0    = '{data_s1, CLS_IGNORED, 8'h00, err_q, 1'b0};
			n_res = 2'd1;
		end else begin
			unique case (phase_q)
				PH_EXPECT: begin
					n_res = 2'd1;
					if (data_s1 == BYTE_FF) begin
						fill_n = fill_q + 4'd1;
						if (fill_n >= FILL_LIMIT) err_n = ERR_FILL;
						r0 = '{data_s1, CLS_FILL, 8'h00, err_n, 1'b0};
					end else begin
						fill_n = 4'd0;
						if (data_s1 < marker_low_q || data_s1 > marker_high_q) begin
							err_n = ERR_BAD_CODE;
							r0 = '{data_s1, CLS_MARKER, data_s1, ERR_BAD_CODE, 1'b0};
						end else begin
							cur_n = data_s1;
							r0 = '{data_s1, CLS_MARKER, data_s1, ERR_NONE, 1'b0};
							if (data_s1 == CODE_EOI && image_q) phase_n = PH_PADDING;
							else if (data_s1 != CODE_SOI && data_s1 != CODE_EOI)
								phase_n = PH_LEN_HI;
						end
					end
				end
				PH_LEN_HI: begin
					left_n  = {data_s1, 8'h00};
					r0      = '{data_s1, CLS_LENGTH, cur_q, ERR_NONE, 1'b0};
					n_res   = 2'd1;
					phase_n = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					n_res = 2'd1;
					if (len < 16'd2) begin
						err_n = ERR_SHORT_LEN;
						r0 = '{data_s1, CLS_LENGTH, cur_q, ERR_SHORT_LEN, 1'b0};
					end else begin
						left_n = len - 16'd2;
						r0 = '{data_s1, CLS_LENGTH, cur_q, ERR_NONE, 1'b0};
						if (left_n != 16'd0) phase_n = PH_PAYLOAD;
						else if (cur_q == CODE_SOS) begin
							phase_n = PH_ENTROPY;
							image_n = 1'b1;
						end else phase_n = PH_EXPECT;
					end
				end
				PH_PAYLOAD: begin
					if (left_q != 16'd0) left_n = left_q - 16'd1;
					r0    = '{data_s1, CLS_PAYLOAD, cur_q, ERR_NONE, 1'b0};
					n_res = 2'd1;
					if (left_n != 16'd0) phase_n = PH_PAYLOAD;
					else if (cur_q == CODE_SOS) begin
						phase_n = PH_ENTROPY;
						image_n = 1'b1;
					end else phase_n = PH_EXPECT;
				end
				PH_ENTROPY: begin
					// release a held 0xFF, as EOI prefix or as image data
					if (held_q) begin
						held_n = 1'b0;
						if (data_s1 == CODE_EOI) begin
							eoi_hit = 1'b1;
							r0      = '{BYTE_FF, CLS_FILL, 8'h00, ERR_NONE, 1'b0};
							r1      = '{data_s1, CLS_MARKER, data_s1, ERR_NONE, 1'b0};
							n_res   = 2'd2;
							cur_n   = CODE_EOI;
							phase_n = PH_PADDING;
						end else begin
							r0    = '{BYTE_FF, CLS_IMAGE, cur_q, ERR_NONE, 1'b0};
							n_res = 2'd1;
						end
					end
					if (!eoi_hit) begin
						if (data_s1 == BYTE_FF && !last_s1) held_n = 1'b1;
						else if (n_res == 2'd1) begin
							r1    = '{data_s1, CLS_IMAGE, cur_q, ERR_NONE, 1'b0};
							n_res = 2'd2;
						end else begin
							r0    = '{data_s1, CLS_IMAGE, cur_q, ERR_NONE, 1'b0};
							n_res = 2'd1;
						end
					end
				end
				default: begin
					r0    = '{data_s1, CLS_PADDING, cur_q, ERR_NONE, 1'b0};
					n_res = 2'd1;
				end
			endcase
		end

		// flag truncation on the final result and restart for the next file
		if (last_s1) begin
			trunc = phase_n == PH_LEN_HI || phase_n == PH_LEN_LO ||
				phase_n == PH_PAYLOAD || (phase_n == PH_EXPECT && fill_n != 4'd0);
			if (trunc && err_n == ERR_NONE) begin
				if (n_res == 2'd2) r1.err = ERR_TRUNC;
				else if (n_res == 2'd1) r0.err = ERR_TRUNC;
			end
			phase_n = PH_EXPECT;
			fill_n  = 4'd0;
			left_n  = 16'd0;
			cur_n   = 8'h00;
			held_n  = 1'b0;
			image_n = 1'b0;
			err_n   = ERR_NONE;
		end

		// mark the final result of this byte
		if (n_res == 2'd2) r1.last = 1'b1;
		else if (n_res == 2'd1) r0.last = 1'b1;
	end

	// hold configuration, input register, parser state and queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_low_q  <= MARKER_LOW_RST;
			marker_high_q <= MARKER_HIGH_RST;
			valid_s1      <= 1'b0;
			phase_q       <= PH_EXPECT;
			fill_q        <= 4'd0;
			left_q        <= 16'd0;
			cur_q         <= 8'h00;
			held_q        <= 1'b0;
			image_q       <= 1'b0;
			err_q         <= ERR_NONE;
			wr_ptr_q      <= 2'd0;
			rd_ptr_q      <= 2'd0;
			count_q       <= 3'd0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_MARKER_LOW:  marker_low_q  <= cfg_data;
					CFG_MARKER_HIGH: marker_high_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) begin
				phase_q <= phase_n;
				fill_q  <= fill_n;
				left_q  <= left_n;
				cur_q   <= cur_n;
				held_q  <= held_n;
				image_q <= image_n;
				err_q   <= err_n;
			end
			wr_ptr_q <= wr_ptr_q + push;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push} - {2'b00, pop};
		end
	end

	// capture the input beat and the result entries
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (push != 2'd0) queue_q[wr_ptr_q] <= r0;
		if (push == 2'd2) queue_q[wr_ptr_q + 2'd1] <= r1;
	end

	// drive the head of the queue
	assign out_valid   = count_q != 3'd0;
	assign byte_value  = queue_q[rd_ptr_q].value;
	assign byte_class  = queue_q[rd_ptr_q].cls;
	assign marker_code = queue_q[rd_ptr_q].marker;
	assign error_code  = queue_q[rd_ptr_q].err;
	assign last_of_run = queue_q[rd_ptr_q].last;

endmodule

`default_nettype wire

FILE: hdl/jmsp_checker.sv
`default_nettype none

`include "jpeg_marker_segment_parser_core_assert.svh"

module jmsp_checker
	import jmsp_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] byte_value,
	input wire logic [2:0] byte_class,
	input wire logic [7:0] marker_code,
	input wire logic [2:0] error_code
);

	// hold a stalled result beat
	`JMSP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(byte_value) && $stable(byte_class) && $stable(error_code))

	// ignored bytes carry a stored error and no marker
	`JMSP_ASSERT_NOW(a_ignored_err, clk, arst_n, out_valid && byte_class == CLS_IGNORED,
		marker_code == 8'h00 && error_code != ERR_NONE)

	// a marker code byte names itself
	`JMSP_ASSERT_NOW(a_marker_self, clk, arst_n, out_valid && byte_class == CLS_MARKER,
		marker_code == byte_value)

	// fill bytes are 0xFF with the code not yet known
	`JMSP_ASSERT_NOW(a_fill_ff, clk, arst_n, out_valid && byte_class == CLS_FILL,
		byte_value == BYTE_FF && marker_code == 8'h00)

	// a short length is flagged only on a length byte or after it
	`JMSP_ASSERT_NOW(a_short_len, clk, arst_n, out_valid && error_code == ERR_SHORT_LEN,
		byte_class == CLS_LENGTH || byte_class == CLS_IGNORED)

endmodule

bind jpeg_marker_segment_parser_core jmsp_checker u_jmsp_checker (.*);

`default_nettype wire
